[rtl/mobile_identity_decoder_unit_defines.svh]
// Assertion helpers shared by the decoder RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MOBILE_IDENTITY_DECODER_UNIT_DEFINES_SVH
`define MOBILE_IDENTITY_DECODER_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define MID_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MID_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mid_pkg.sv]
package mid_pkg;

    // Field widths of the byte and result words.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int TYPE_W  = 3;
    localparam int COUNT_W = 4;
    localparam int STAT_W  = 2;

    // Default digit limit of an identity.
    localparam int MAX_DIGITS_DEFAULT = 15;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_DIGIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TMSI    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // Identity types.
    localparam logic [TYPE_W-1:0] ID_NONE   = 3'd0;
    localparam logic [TYPE_W-1:0] ID_IMSI   = 3'd1;
    localparam logic [TYPE_W-1:0] ID_IMEI   = 3'd2;
    localparam logic [TYPE_W-1:0] ID_IMEISV = 3'd3;
    localparam logic [TYPE_W-1:0] ID_TMSI   = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_MANY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TRUNCATED = 2'd2;

    // Number of TMSI bytes that make one word.
    localparam logic [2:0] TMSI_BYTES = 3'd4;

    // One result word without its end-of-run flag.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [TYPE_W-1:0]  id_type;
        logic [COUNT_W-1:0] digit_count;
        logic [STAT_W-1:0]  status;
    } result_t;

    // All results caused by one byte, oldest in entry 0.
    typedef struct packed {
        logic [1:0]        cnt;
        result_t [2:0]     res;
    } bundle_t;

endpackage

[rtl/mid_byte_if.sv]
interface mid_byte_if
    import mid_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              is_last;

    modport source (output valid, output byte_in, output is_last, input ready);
    modport sink   (input valid, input byte_in, input is_last, output ready);
endinterface

[rtl/mid_result_if.sv]
interface mid_result_if
    import mid_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [TYPE_W-1:0]  id_type;
    logic [COUNT_W-1:0] digit_count;
    logic [STAT_W-1:0]  status;
    logic               last_of_run;

    modport source (output valid, output kind, output value, output id_type,
                    output digit_count, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input value, input id_type,
                    input digit_count, input status, input last_of_run,
                    output ready);
endinterface

[rtl/mobile_identity_decoder_unit.sv]
// Mobile identity decoder. Takes the value part of a mobile identity element one
// byte per word and returns BCD digits (IMSI, IMEI, IMEISV), one 32-bit TMSI word,
// and an end summary on the byte marked last. A byte is decoded in the cycle it is
// accepted and its results (zero to three) go into a two-entry result buffer; the
// first result is offered once its entry reaches the head of the buffer. The single
// result port moves one word per cycle while the sink is ready: a byte that makes
// at most one result uses one word, a middle digit byte two, and a last digit byte
// that ends with two digits and the summary three. The input stays ready while the
// buffer has a free entry.
`include "mobile_identity_decoder_unit_defines.svh"

module mobile_identity_decoder_unit
    import mid_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    mid_byte_if.sink            byte_ch,
    mid_result_if.source        result_ch
);

    localparam int DS_W = $clog2(MAX_DIGITS + 1);
    localparam logic [DS_W-1:0] MAX_DS = DS_W'(MAX_DIGITS);

    // Decoder state.
    logic               started_reg,  started_next;
    logic [TYPE_W-1:0]  kind_held_reg, kind_held_next;
    logic               odd_reg,      odd_next;
    logic [DS_W-1:0]    ds_reg,       ds_next;
    logic [VALUE_W-1:0] tmsi_reg,     tmsi_next;
    logic [2:0]         tb_reg,       tb_next;
    logic [STAT_W-1:0]  err_reg,      err_next;

    // Result buffer.
    bundle_t            bundle_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         fill_reg;
    logic [1:0]         sel_reg;

    logic               in_fire;
    logic               out_fire;
    logic               push;
    logic               pop;
    bundle_t            new_bundle;
    bundle_t            head;
    logic [1:0]         last_sel;

    assign byte_ch.ready = (fill_reg != 2'd2);
    assign in_fire       = byte_ch.valid && byte_ch.ready;

    // Decode one byte against the current state.
    always_comb
    begin
        logic [BYTE_W-1:0] b;
        logic              last;
        logic [1:0]        take;
        logic [3:0]        nib [2];
        logic [1:0]        n;
        result_t           r;

        b    = byte_ch.byte_in;
        last = byte_ch.is_last;
        take = 2'b00;
        nib[0] = b[7:4];
        nib[1] = b[7:4];
        n    = 2'd0;
        r    = '0;
        new_bundle = '0;

        started_next   = started_reg;
        kind_held_next = kind_held_reg;
        odd_next       = odd_reg;
        ds_next        = ds_reg;
        tmsi_next      = tmsi_reg;
        tb_next        = tb_reg;
        err_next       = err_reg;

        if (!started_reg)
        begin
            // First byte: type, odd flag and digit one.
            started_next   = 1'b1;
            odd_next       = b[3];
            ds_next        = '0;
            tmsi_next      = '0;
            tb_next        = '0;
            err_next       = STAT_OK;
            kind_held_next = (b[2:0] >= ID_IMSI && b[2:0] <= ID_TMSI) ? b[2:0] : ID_NONE;
            if (kind_held_next >= ID_IMSI && kind_held_next <= ID_IMEISV)
            begin
                take[0] = !(last && !b[3]);
            end
        end
        else if (kind_held_reg >= ID_IMSI && kind_held_reg <= ID_IMEISV)
        begin
            // Later digit byte: low nibble, then high nibble unless it is filler.
            take[0] = 1'b1;
            nib[0]  = b[3:0];
            take[1] = !(last && !odd_reg);
        end
        else if (kind_held_reg == ID_TMSI)
        begin
            // Gather TMSI bytes big-endian.
            if (tb_reg < TMSI_BYTES)
            begin
                tmsi_next = {tmsi_reg[VALUE_W-BYTE_W-1:0], b};
                tb_next   = tb_reg + 3'd1;
                if (tb_next == TMSI_BYTES)
                begin
                    r             = '0;
                    r.kind        = KIND_TMSI;
                    r.value       = tmsi_next;
                    r.id_type     = kind_held_reg;
                    r.digit_count = '0;
                    r.status      = err_reg;
                    new_bundle.res[n] = r;
                    n = n + 2'd1;
                end
            end
        end

        // Digits past the limit are dropped and flagged.
        for (int i = 0; i < 2; i++)
        begin
            if (take[i])
            begin
                if (ds_next < MAX_DS)
                begin
                    ds_next       = ds_next + DS_W'(1);
                    r             = '0;
                    r.kind        = KIND_DIGIT;
                    r.value       = VALUE_W'(nib[i]);
                    r.id_type     = kind_held_next;
                    r.digit_count = COUNT_W'(ds_next);
                    r.status      = err_next;
                    new_bundle.res[n] = r;
                    n = n + 2'd1;
                end
                else
                begin
                    err_next = STAT_TOO_MANY;
                end
            end
        end

        // End summary, then back to the reset state.
        if (last)
        begin
            if (kind_held_next == ID_TMSI && tb_next < TMSI_BYTES)
            begin
                err_next = STAT_TRUNCATED;
            end
            r             = '0;
            r.kind        = KIND_SUMMARY;
            r.value       = '0;
            r.id_type     = kind_held_next;
            r.digit_count = COUNT_W'(ds_next);
            r.status      = err_next;
            new_bundle.res[n] = r;
            n = n + 2'd1;

            started_next   = 1'b0;
            kind_held_next = ID_NONE;
            odd_next       = 1'b0;
            ds_next        = '0;
            tmsi_next      = '0;
            tb_next        = '0;
            err_next       = STAT_OK;
        end

        new_bundle.cnt = n;
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            kind_held_reg <= ID_NONE;
            odd_reg       <= 1'b0;
            ds_reg        <= '0;
            tmsi_reg      <= '0;
            tb_reg        <= '0;
            err_reg       <= STAT_OK;
        end
        else if (in_fire)
        begin
            started_reg   <= started_next;
            kind_held_reg <= kind_held_next;
            odd_reg       <= odd_next;
            ds_reg        <= ds_next;
            tmsi_reg      <= tmsi_next;
            tb_reg        <= tb_next;
            err_reg       <= err_next;
        end
    end

    // Result buffer control.
    assign head      = bundle_reg[rd_ptr_reg];
    assign last_sel  = head.cnt - 2'd1;
    assign out_fire  = result_ch.valid && result_ch.ready;
    assign push      = in_fire && (new_bundle.cnt != 2'd0);
    assign pop       = out_fire && (sel_reg == last_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            sel_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
                sel_reg    <= 2'd0;
            end
            else if (out_fire)
            begin
                sel_reg <= sel_reg + 2'd1;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Buffer storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bundle_reg[wr_ptr_reg] <= new_bundle;
        end
    end

    // Output word.
    assign result_ch.valid       = (fill_reg != 2'd0);
    assign result_ch.kind        = head.res[sel_reg].kind;
    assign result_ch.value       = head.res[sel_reg].value;
    assign result_ch.id_type     = head.res[sel_reg].id_type;
    assign result_ch.digit_count = head.res[sel_reg].digit_count;
    assign result_ch.status      = head.res[sel_reg].status;
    assign result_ch.last_of_run = (sel_reg == last_sel);

    // Index of the final result in a freshly decoded bundle.
    function automatic logic [1:0] last_sel_new(input logic [1:0] cnt);
        last_sel_new = cnt - 2'd1;
    endfunction

    // Checks on the buffer and decoder state.
    `MID_ASSERT_ALWAYS(a_fill_bound, fill_reg <= 2'd2, "result buffer overfilled")
    `MID_ASSERT_IMPLY(a_head_nonempty, result_ch.valid, head.cnt != 2'd0 && sel_reg < head.cnt,
        "output select beyond buffered results")
    `MID_ASSERT_NEXT(a_last_resets, in_fire && byte_ch.is_last, !started_reg && err_reg == STAT_OK,
        "decoder not back at reset after last byte")
    `MID_ASSERT_ALWAYS(a_digit_limit, ds_reg <= MAX_DS, "digit count beyond limit")
    `MID_ASSERT_IMPLY(a_last_summary, in_fire && byte_ch.is_last,
        new_bundle.res[last_sel_new(new_bundle.cnt)].kind == KIND_SUMMARY,
        "last byte without end summary")

endmodule
